@@ rtl/dfst_pkg.sv @@
// ----------------------------------------------------------------------------
// dfst_pkg
// Shared types and constants for the depth-first search timestamp unit.
// ----------------------------------------------------------------------------
package dfst_pkg;

  localparam int unsigned VERT_W = 6;
  localparam int unsigned TIME_W = 8;
  localparam int unsigned CFG_W  = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [VERT_W-1:0] from_vertex;
    logic [VERT_W-1:0] to_vertex;
  } in_item_t;

  typedef struct packed {
    logic [VERT_W-1:0] vertex_index;
    logic              has_parent;
    logic [VERT_W-1:0] parent_vertex;
    logic [TIME_W-1:0] discover_time;
    logic [TIME_W-1:0] finish_time;
    logic              edges_dropped;
    logic              last;
  } out_item_t;

endpackage

@@ rtl/dfst_ram.sv @@
// ----------------------------------------------------------------------------
// dfst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dfst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/depth_first_search_timestamps_unit.sv @@
// ----------------------------------------------------------------------------
// depth_first_search_timestamps_unit
// Edge list store plus a stack-based depth-first walk that records discovery
// time, finish time and predecessor of every vertex, then reports them.
// ----------------------------------------------------------------------------
//  Channel  | Signals                            | Direction
//  in       | in_valid_i, in_stall_o, in_data_i  | edge add / search / clear
//  out      | out_valid_o, out_stall_i, out_data_o | one result per vertex
//  cfg      | cfg_we_i, cfg_wdata_i              | vertex_count write
//
//  Clear is handled in idle; an edge add does a tail lookup, then the edge
//  write and, for a non-empty list, the link write. A search discovers roots,
//  reads stored edges and finishes vertices (each step using registered memory
//  reads), then delivers one result per vertex, held while out_stall_i is set.
//  Input is stalled from acceptance of a search until its last result transfers.
//  Reset empties the edge lists at once (per-vertex head valid flops).
// ----------------------------------------------------------------------------
module depth_first_search_timestamps_unit #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dfst_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dfst_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i
);

  import dfst_pkg::*;

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned NW  = VW + 1;
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned IW  = 1 + VW + TIME_W;
  localparam int unsigned SW  = VW + EW;
  localparam logic [EW-1:0] NO_LINK = EW'(MAX_EDGES);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_WR, S_ADD_LINK, S_ROOT, S_DISC, S_STEP, S_EDGE, S_POP,
    S_ORD, S_OCAP, S_OWAIT
  } state_e;

  state_e state_q, state_d;
  logic [CFG_W-1:0] vc_q, vc_d;
  logic [NW-1:0] n_q, n_d, root_q, root_d, depth_q, depth_d, dm1, dm2;
  logic [EW-1:0] fill_q, fill_d, eidx_q, eidx_d, link_q, link_d, top_c_q, top_c_d;
  logic drop_q, drop_d, hv_q, hv_d, out_valid_q, out_valid_d;
  logic [MAX_VERTICES-1:0] hvld_q, hvld_d, disc_q, disc_d;
  logic [VW-1:0] from_q, from_d, to_q, to_d, top_v_q, top_v_d, dv_q, dv_d, ov_q, ov_d;
  logic [TIME_W-1:0] time_q, time_d;
  out_item_t out_q, out_d;

  // memory ports
  logic head_we, head_re, tail_we, tail_re, tgt_we, nxt_we, edge_re;
  logic info_we, fin_we, out_re, stk_we, stk_re;
  logic [VW-1:0] head_raddr, info_waddr;
  logic [EAW-1:0] nxt_waddr;
  logic [EW-1:0] nxt_wdata, head_rdata, tail_rdata, nxt_rdata;
  logic [VW-1:0] tgt_rdata;
  logic [IW-1:0] info_wdata, info_rdata;
  logic [TIME_W-1:0] fin_rdata;
  logic [SW-1:0] stk_rdata;
  logic [VW-1:0] root_v, cand;

  assign dm1    = depth_q - NW'(1);
  assign dm2    = depth_q - NW'(2);
  assign root_v = root_q[VW-1:0];
  assign cand   = tgt_rdata;

  always_comb begin
    state_d     = state_q;
    vc_d        = vc_q;
    n_d         = n_q;
    root_d      = root_q;
    depth_d     = depth_q;
    fill_d      = fill_q;
    eidx_d      = eidx_q;
    link_d      = link_q;
    top_c_d     = top_c_q;
    top_v_d     = top_v_q;
    drop_d      = drop_q;
    hv_d        = hv_q;
    hvld_d      = hvld_q;
    disc_d      = disc_q;
    from_d      = from_q;
    to_d        = to_q;
    dv_d        = dv_q;
    ov_d        = ov_q;
    time_d      = time_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    head_we = 1'b0; head_re = 1'b0; tail_we = 1'b0; tail_re = 1'b0;
    tgt_we = 1'b0; nxt_we = 1'b0; edge_re = 1'b0; info_we = 1'b0;
    fin_we = 1'b0; out_re = 1'b0; stk_we = 1'b0; stk_re = 1'b0;
    head_raddr = root_v;
    info_waddr = root_v;
    info_wdata = {1'b0, {VW{1'b0}}, time_q + 8'd1};
    nxt_waddr  = eidx_q[EAW-1:0];
    nxt_wdata  = NO_LINK;

    if (cfg_we_i) begin
      vc_d = cfg_wdata_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.req_type)
            REQ_ADD: begin
              if (int'(in_data_i.from_vertex) < MAX_VERTICES &&
                  int'(in_data_i.to_vertex) < MAX_VERTICES) begin
                if (fill_q >= NO_LINK) begin
                  drop_d = 1'b1;
                end else begin
                  from_d  = in_data_i.from_vertex[VW-1:0];
                  to_d    = in_data_i.to_vertex[VW-1:0];
                  eidx_d  = fill_q;
                  fill_d  = fill_q + EW'(1);
                  tail_re = 1'b1;
                  state_d = S_ADD_WR;
                end
              end
            end
            REQ_SEARCH: begin
              if (vc_q == '0) begin
                n_d = NW'(1);
              end else if (int'(vc_q) > MAX_VERTICES) begin
                n_d = NW'(MAX_VERTICES);
              end else begin
                n_d = NW'(vc_q);
              end
              disc_d  = '0;
              time_d  = '0;
              depth_d = '0;
              root_d  = '0;
              state_d = S_ROOT;
            end
            REQ_CLEAR: begin
              hvld_d = '0;
              fill_d = '0;
              drop_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_ADD_WR: begin
        tgt_we  = 1'b1;
        nxt_we  = 1'b1;
        tail_we = 1'b1;
        if (hvld_q[from_q]) begin
          link_d  = tail_rdata;
          state_d = S_ADD_LINK;
        end else begin
          head_we        = 1'b1;
          hvld_d[from_q] = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_ADD_LINK: begin
        nxt_we    = 1'b1;
        nxt_waddr = link_q[EAW-1:0];
        nxt_wdata = eidx_q;
        state_d   = S_IDLE;
      end
      S_ROOT: begin
        if (root_q >= n_q) begin
          ov_d    = '0;
          state_d = S_ORD;
        end else if (disc_q[root_v]) begin
          root_d = root_q + NW'(1);
        end else begin
          // discover a tree root
          disc_d[root_v] = 1'b1;
          time_d         = time_q + 8'd1;
          info_we        = 1'b1;
          head_re        = 1'b1;
          hv_d           = hvld_q[root_v];
          dv_d           = root_v;
          state_d        = S_DISC;
        end
      end
      S_DISC: begin
        // push the old top below the newly discovered vertex
        if (depth_q != '0) begin
          stk_we = 1'b1;
        end
        top_v_d = dv_q;
        top_c_d = hv_q ? head_rdata : NO_LINK;
        depth_d = depth_q + NW'(1);
        state_d = S_STEP;
      end
      S_STEP: begin
        if (depth_q == '0) begin
          state_d = S_ROOT;
        end else if (top_c_q >= NO_LINK) begin
          time_d  = time_q + 8'd1;
          fin_we  = 1'b1;
          depth_d = dm1;
          if (depth_q >= NW'(2)) begin
            stk_re  = 1'b1;
            state_d = S_POP;
          end
        end else begin
          edge_re = 1'b1;
          state_d = S_EDGE;
        end
      end
      S_EDGE: begin
        top_c_d = nxt_rdata;
        if (NW'(cand) < n_q && !disc_q[cand]) begin
          disc_d[cand] = 1'b1;
          time_d       = time_q + 8'd1;
          info_we      = 1'b1;
          info_waddr   = cand;
          info_wdata   = {1'b1, top_v_q, time_q + 8'd1};
          head_re      = 1'b1;
          head_raddr   = cand;
          hv_d         = hvld_q[cand];
          dv_d         = cand;
          state_d      = S_DISC;
        end else begin
          state_d = S_STEP;
        end
      end
      S_POP: begin
        top_v_d = stk_rdata[SW-1:EW];
        top_c_d = stk_rdata[EW-1:0];
        state_d = S_STEP;
      end
      S_ORD: begin
        out_re  = 1'b1;
        state_d = S_OCAP;
      end
      S_OCAP: begin
        out_d.vertex_index  = VERT_W'(ov_q);
        out_d.has_parent    = info_rdata[IW-1];
        out_d.parent_vertex = VERT_W'(info_rdata[IW-2:TIME_W]);
        out_d.discover_time = info_rdata[TIME_W-1:0];
        out_d.finish_time   = fin_rdata;
        out_d.edges_dropped = drop_q;
        out_d.last          = (NW'(ov_q) + NW'(1)) == n_q;
        out_valid_d         = 1'b1;
        state_d             = S_OWAIT;
      end
      S_OWAIT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (out_q.last) begin
            state_d = S_IDLE;
          end else begin
            ov_d    = ov_q + VW'(1);
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vc_q        <= CFG_RESET;
      n_q         <= NW'(1);
      root_q      <= '0;
      depth_q     <= '0;
      fill_q      <= '0;
      drop_q      <= 1'b0;
      hvld_q      <= '0;
      disc_q      <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vc_q        <= vc_d;
      n_q         <= n_d;
      root_q      <= root_d;
      depth_q     <= depth_d;
      fill_q      <= fill_d;
      drop_q      <= drop_d;
      hvld_q      <= hvld_d;
      disc_q      <= disc_d;
      time_q      <= time_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    eidx_q  <= eidx_d;
    link_q  <= link_d;
    top_c_q <= top_c_d;
    top_v_q <= top_v_d;
    hv_q    <= hv_d;
    from_q  <= from_d;
    to_q    <= to_d;
    dv_q    <= dv_d;
    ov_q    <= ov_d;
    out_q   <= out_d;
  end

  dfst_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(from_q), .wdata_i(eidx_q),
    .re_i(head_re), .raddr_i(head_raddr), .rdata_o(head_rdata)
  );

  dfst_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_tail (
    .clk_i, .we_i(tail_we), .waddr_i(from_q), .wdata_i(eidx_q),
    .re_i(tail_re), .raddr_i(in_data_i.from_vertex[VW-1:0]), .rdata_o(tail_rdata)
  );

  dfst_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_target (
    .clk_i, .we_i(tgt_we), .waddr_i(eidx_q[EAW-1:0]), .wdata_i(to_q),
    .re_i(edge_re), .raddr_i(top_c_q[EAW-1:0]), .rdata_o(tgt_rdata)
  );

  dfst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_next (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .re_i(edge_re), .raddr_i(top_c_q[EAW-1:0]), .rdata_o(nxt_rdata)
  );

  dfst_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES)) u_info (
    .clk_i, .we_i(info_we), .waddr_i(info_waddr), .wdata_i(info_wdata),
    .re_i(out_re), .raddr_i(ov_q), .rdata_o(info_rdata)
  );

  dfst_ram #(.WIDTH(TIME_W), .DEPTH(MAX_VERTICES)) u_finish (
    .clk_i, .we_i(fin_we), .waddr_i(top_v_q), .wdata_i(time_q + 8'd1),
    .re_i(out_re), .raddr_i(ov_q), .rdata_o(fin_rdata)
  );

  dfst_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(dm1[VW-1:0]), .wdata_i({top_v_q, top_c_q}),
    .re_i(stk_re), .raddr_i(dm2[VW-1:0]), .rdata_o(stk_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/dfst_checker.sv @@
// ----------------------------------------------------------------------------
// dfst_checker
// Port-level checks for the depth-first search timestamp unit.
// ----------------------------------------------------------------------------
module dfst_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input dfst_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dfst_pkg::out_item_t out_data_o,
  input logic                cfg_we_i,
  input logic [6:0]          cfg_wdata_i
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // no input transfer while results are pending
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during result delivery");

  // a vertex finishes after it is discovered
  a_time_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.discover_time < out_data_o.finish_time)
    else $error("finish time not after discovery");

  // the final result closes the search
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.last |=> !out_valid_o && !in_stall_o)
    else $error("activity after final result");

endmodule

bind depth_first_search_timestamps_unit dfst_checker u_dfst_checker (.*);
